// ===== rtl/core/bdd_pkg.sv =====
package bdd_pkg;

	// default width of the kept difference field
	localparam int unsigned DIFF_BITS_DEF = 32;

	// stream layout
	localparam int unsigned START_BYTES = 8;
	localparam int unsigned HDR_BITS    = 8;
	localparam int unsigned LEN_W       = 7;
	localparam int unsigned VALUE_W     = 64;

	// result word handed to the output register
	typedef struct packed {
		logic signed [VALUE_W-1:0] decoded_value;
		logic                      is_repeat;
	} res_t;

endpackage

// ===== rtl/core/bdd_in_if.sv =====
interface bdd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

// ===== rtl/core/bdd_out_if.sv =====
interface bdd_out_if import bdd_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] decoded_value;
	logic                      is_repeat;

	modport source (output valid, output decoded_value, output is_repeat, input ready);
	modport sink (input valid, input decoded_value, input is_repeat, output ready);
endinterface

// ===== rtl/core/bdd_decode.sv =====
module bdd_decode import bdd_pkg::*; #(
	parameter int unsigned DIFF_BITS = DIFF_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	bdd_in_if.sink   in_ch,
	input  logic     res_ready,
	output logic     res_valid,
	output res_t     res
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;

	// decoder state
	logic [3:0]           start_cnt_q;
	logic [VALUE_W-1:0]   running_q;
	logic                 in_diff_q;
	logic [HDR_BITS-1:0]  hdr_shift_q;
	logic [2:0]           hdr_held_q;
	logic [LEN_W-1:0]     diff_left_q;
	logic [DIFF_BITS-1:0] diff_shift_q;

	// next state and result
	logic [3:0]           start_cnt_d;
	logic [VALUE_W-1:0]   running_d;
	logic                 in_diff_d;
	logic [HDR_BITS-1:0]  hdr_shift_d;
	logic [3:0]           hdr_held_d;
	logic [LEN_W-1:0]     diff_left_d;
	logic [DIFF_BITS-1:0] diff_shift_d;
	logic [DIFF_BITS-1:0] diff_fin;
	logic signed [DIFF_BITS-1:0] diff_sgn;
	logic                 emit;
	logic                 rep;
	logic                 add_diff;

	assign adv          = valid_s1 & res_ready;
	assign in_ch.ready  = ~valid_s1 | res_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.stream_byte;
		end
	end

	// bit walk over one byte, at most one record ends per byte
	always_comb begin
		start_cnt_d  = start_cnt_q;
		running_d    = running_q;
		in_diff_d    = in_diff_q;
		hdr_shift_d  = hdr_shift_q;
		hdr_held_d   = {1'b0, hdr_held_q};
		diff_left_d  = diff_left_q;
		diff_shift_d = diff_shift_q;
		diff_fin     = '0;
		diff_sgn     = '0;
		emit         = 1'b0;
		rep          = 1'b0;
		add_diff     = 1'b0;
		if (start_cnt_q < 4'(START_BYTES)) begin
			running_d   = running_q | (VALUE_W'(byte_s1) << {start_cnt_q[2:0], 3'b000});
			start_cnt_d = start_cnt_q + 4'd1;
			emit        = (start_cnt_q == 4'(START_BYTES - 1));
		end else begin
			for (int i = 7; i >= 0; i--) begin
				if (!in_diff_d) begin
					hdr_shift_d = {hdr_shift_d[HDR_BITS-2:0], byte_s1[i]};
					hdr_held_d  = hdr_held_d + 4'd1;
					if (hdr_held_d == 4'(HDR_BITS)) begin
						hdr_held_d = '0;
						if (!hdr_shift_d[HDR_BITS-1]) begin
							emit = 1'b1;
							rep  = 1'b1;
						end else if (hdr_shift_d[LEN_W-1:0] == '0) begin
							emit = 1'b1;
						end else begin
							in_diff_d    = 1'b1;
							diff_left_d  = hdr_shift_d[LEN_W-1:0];
							diff_shift_d = '0;
						end
						hdr_shift_d = '0;
					end
				end else begin
					diff_shift_d = {diff_shift_d[DIFF_BITS-2:0], byte_s1[i]};
					diff_left_d  = diff_left_d - LEN_W'(1);
					if (diff_left_d == '0) begin
						diff_fin     = diff_shift_d;
						add_diff     = 1'b1;
						emit         = 1'b1;
						in_diff_d    = 1'b0;
						diff_shift_d = '0;
					end
				end
			end
			// one wide add for the completed difference
			diff_sgn = diff_fin;
			if (add_diff) begin
				running_d = running_q + VALUE_W'(diff_sgn);
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_cnt_q  <= '0;
			running_q    <= '0;
			in_diff_q    <= 1'b0;
			hdr_shift_q  <= '0;
			hdr_held_q   <= '0;
			diff_left_q  <= '0;
			diff_shift_q <= '0;
		end else if (adv) begin
			start_cnt_q  <= start_cnt_d;
			running_q    <= running_d;
			in_diff_q    <= in_diff_d;
			hdr_shift_q  <= hdr_shift_d;
			hdr_held_q   <= hdr_held_d[2:0];
			diff_left_q  <= diff_left_d;
			diff_shift_q <= diff_shift_d;
		end
	end

	// result word towards the output register
	assign res_valid         = adv & emit;
	assign res.decoded_value = running_d;
	assign res.is_repeat     = rep;

endmodule

// ===== rtl/core/bdd_out_reg.sv =====
module bdd_out_reg import bdd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  res_t      res,
	output logic      res_ready,
	bdd_out_if.source out_ch
);

	logic valid_q;
	res_t res_q;

	// register accepts when empty or when its word is being taken
	assign res_ready = ~valid_q | out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_ch.valid         = valid_q;
	assign out_ch.decoded_value = res_q.decoded_value;
	assign out_ch.is_repeat     = res_q.is_repeat;

endmodule

// ===== rtl/core/bitpacked_delta_decoder_core.sv =====
// a byte is held in the input register and decoded, and its word is then registered
// in the output register; a full output register holds the input register back
// throughput: one stream byte per cycle unless the output register stalls, set by
// the single decode pass between the input register and the output register
// reset: arst_n clears the start count, running value and record state at once;
// the next byte accepted is the first byte of the start value
module bitpacked_delta_decoder_core import bdd_pkg::*; #(
	parameter int unsigned DIFF_BITS = DIFF_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bdd_in_if.sink    in_ch,
	bdd_out_if.source out_ch
);

	logic res_valid;
	logic res_ready;
	res_t res;

	// byte decode with input register and decoder state
	bdd_decode #(
		.DIFF_BITS(DIFF_BITS)
	) u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res      (res)
	);

	// result register
	bdd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res      (res),
		.res_ready(res_ready),
		.out_ch   (out_ch)
	);

endmodule

// ===== tb/bdd_checker.sv =====
`timescale 1ns / 1ps

// watches both channels, decodes the accepted stream bytes on its own and
// compares every accepted output word with the oldest predicted one
module bdd_checker import bdd_pkg::*; #(
	parameter int unsigned DIFF_BITS = DIFF_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bdd_in_if           in_ch,
	bdd_out_if          out_ch,
	output int unsigned mismatches,
	output int unsigned words_pending
);

	localparam logic [VALUE_W-1:0] DIFF_MASK =
		(DIFF_BITS >= VALUE_W) ? '1 : ((64'd1 << DIFF_BITS) - 64'd1);
	localparam int unsigned REPORT_MAX = 10;

	// decoder state mirrored from the stream
	int unsigned        start_seen;
	logic [VALUE_W-1:0] run_val;
	logic               in_diff;
	logic [7:0]         hdr;
	int unsigned        hdr_held;
	int unsigned        bits_left;
	logic [VALUE_W-1:0] diff_acc;

	res_t expected_words[$];

	function automatic logic [VALUE_W-1:0] sign_extend(input logic [VALUE_W-1:0] d);
		if (d[DIFF_BITS-1])
			return d | ~DIFF_MASK;
		return d & DIFF_MASK;
	endfunction

	task automatic expect_word(input logic [VALUE_W-1:0] v, input logic rep);
		res_t w;
		begin
			w.decoded_value = v;
			w.is_repeat     = rep;
			expected_words.push_back(w);
		end
	endtask

	task automatic note_mismatch(input string msg);
		begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t: %s", $realtime, msg);
		end
	endtask

	// one stream byte: start value bytes first, then records msb first
	task automatic decode_byte(input logic [7:0] b);
		begin
			if (start_seen < START_BYTES) begin
				run_val[start_seen*8 +: 8] = b;
				start_seen++;
				if (start_seen == START_BYTES)
					expect_word(run_val, 1'b0);
			end else begin
				for (int i = 7; i >= 0; i--) begin
					if (!in_diff) begin
						hdr = {hdr[6:0], b[i]};
						hdr_held++;
						if (hdr_held == HDR_BITS) begin
							hdr_held = 0;
							// type 0 ignores its length, type 1 with length 0 adds nothing
							if (!hdr[7])
								expect_word(run_val, 1'b1);
							else if (hdr[LEN_W-1:0] == '0)
								expect_word(run_val, 1'b0);
							else begin
								in_diff   = 1'b1;
								bits_left = hdr[LEN_W-1:0];
								diff_acc  = '0;
							end
							hdr = '0;
						end
					end else begin
						// only the last DIFF_BITS bits of a long difference survive
						diff_acc = ((diff_acc << 1) | VALUE_W'(b[i])) & DIFF_MASK;
						bits_left--;
						if (bits_left == 0) begin
							run_val  = run_val + sign_extend(diff_acc);
							in_diff  = 1'b0;
							diff_acc = '0;
							expect_word(run_val, 1'b0);
						end
					end
				end
			end
		end
	endtask

	task automatic check_word(input logic [VALUE_W-1:0] v, input logic rep);
		res_t w;
		begin
			if (expected_words.size() == 0) begin
				note_mismatch($sformatf("unexpected word: value %h repeat %b", v, rep));
			end else begin
				w = expected_words.pop_front();
				if (v !== w.decoded_value)
					note_mismatch($sformatf("decoded_value: expected %h, got %h",
						w.decoded_value, v));
				if (rep !== w.is_repeat)
					note_mismatch($sformatf("is_repeat: expected %b, got %b (value %h)",
						w.is_repeat, rep, w.decoded_value));
			end
		end
	endtask

	// inputs are decoded before the output is checked, so a word made in the
	// same cycle still lines up behind the older ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_seen = 0;
			run_val    = '0;
			in_diff    = 1'b0;
			hdr        = '0;
			hdr_held   = 0;
			bits_left  = 0;
			diff_acc   = '0;
			expected_words.delete();
			mismatches    = 0;
			words_pending = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				decode_byte(in_ch.stream_byte);
			if (out_ch.valid && out_ch.ready)
				check_word(out_ch.decoded_value, out_ch.is_repeat);
			words_pending = expected_words.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bdd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned DRAIN_WAIT  = 8;

	logic clk;
	logic arst_n;

	bdd_in_if  in_ch();
	bdd_out_if out_ch();

	int unsigned mismatches;
	int unsigned words_pending;

	bitpacked_delta_decoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	bdd_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.mismatches    (mismatches),
		.words_pending (words_pending)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_asks;
	int unsigned bytes_sent;
	bit          stream_bits[$];

	// receiver: random ready, plus long hold-offs on request
	initial begin : receiver
		int unsigned hold_seen;
		int unsigned hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// run limit
	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// offer one byte, called at a falling edge, returns at a falling edge
	task automatic push_byte(input logic [7:0] b);
		begin
			while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
				in_ch.valid <= 1'b0;
				@(negedge clk);
			end
			in_ch.valid       <= 1'b1;
			in_ch.stream_byte <= b;
			@(posedge clk);
			while (!in_ch.ready)
				@(posedge clk);
			bytes_sent++;
			@(negedge clk);
		end
	endtask

	task automatic emit_bits(input logic [31:0] v, input int unsigned n);
		begin
			for (int i = n - 1; i >= 0; i--)
				stream_bits.push_back(v[i]);
		end
	endtask

	// send every complete byte held in the bit queue
	task automatic drain_bytes();
		logic [7:0] b;
		begin
			while (stream_bits.size() >= 8) begin
				for (int i = 7; i >= 0; i--)
					b[i] = stream_bits.pop_front();
				push_byte(b);
			end
		end
	endtask

	task automatic emit_difference(input int unsigned len);
		int unsigned left;
		int unsigned part;
		begin
			left = len;
			while (left > 0) begin
				part = (left > 32) ? 32 : left;
				emit_bits($urandom, part);
				left -= part;
			end
		end
	endtask

	// one random record, with the odd stretch of raw bits to shift alignment
	task automatic random_record();
		int unsigned pick;
		int unsigned len;
		begin
			pick = $urandom_range(99, 0);
			if (pick < 6)
				emit_bits($urandom, $urandom_range(8, 1));
			else if (pick < 20)
				emit_bits({24'd0, 1'b0, 7'($urandom)}, 8);
			else if (pick < 27)
				emit_bits(32'h80, 8);
			else begin
				pick = $urandom_range(99, 0);
				if (pick < 10)
					len = $urandom_range(8, 1);
				else if (pick < 65)
					len = $urandom_range(32, 9);
				else if (pick < 85)
					len = $urandom_range(64, 33);
				else
					len = $urandom_range(127, 65);
				emit_bits({24'd0, 1'b1, 7'(len)}, 8);
				emit_difference(len);
			end
			drain_bytes();
		end
	endtask

	task automatic random_until(input int unsigned byte_goal);
		begin
			while (bytes_sent < byte_goal)
				random_record();
		end
	endtask

	task automatic wait_drained();
		begin
			in_ch.valid <= 1'b0;
			while (words_pending != 0)
				@(negedge clk);
		end
	endtask

	initial begin : stimulus
		in_ch.valid       = 1'b0;
		in_ch.stream_byte = '0;
		arst_n            = 1'b0;
		send_idle_pct     = 37;
		recv_idle_pct     = 86;
		hold_asks         = 0;
		bytes_sent        = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// start value near the top of the unsigned range, every bit both ways
		push_byte(8'h00);
		push_byte(8'h55);
		push_byte(8'hAA);
		push_byte(8'h80);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(8'hFF);

		// repeat with its length bits set, repeat with length 0,
		// empty difference, +1, most negative difference,
		// long difference whose top bits are lost, short field across bytes
		emit_bits(32'h7F, 8);
		emit_bits(32'h00, 8);
		emit_bits(32'h80, 8);
		emit_bits(32'h81, 8);
		emit_bits(32'h1, 1);
		emit_bits(32'hA0, 8);
		emit_bits(32'h8000_0000, 32);
		emit_bits(32'hA8, 8);
		emit_bits(32'hC3, 8);
		emit_bits(32'hFFFF_FFFF, 32);
		emit_bits(32'h88, 8);
		emit_bits(32'hFF, 8);
		drain_bytes();

		// phase one: sender idles lightly, receiver heavily
		random_until(70);
		hold_asks++;
		random_until(130);
		wait_drained();
		random_until(150);

		// phase two: the other way round
		send_idle_pct = 86;
		recv_idle_pct = 37;
		random_until(280);

		// phase three: no idling on either side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_until(350);
		hold_asks++;
		random_until(410);

		// pad the last partial byte
		while (stream_bits.size() % 8 != 0)
			stream_bits.push_back(1'b0);
		drain_bytes();

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && words_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/bdd_pkg.sv
rtl/core/bdd_in_if.sv
rtl/core/bdd_out_if.sv
rtl/core/bdd_decode.sv
rtl/core/bdd_out_reg.sv
rtl/core/bitpacked_delta_decoder_core.sv
tb/bdd_checker.sv
tb/tb.sv
